FILE: rtl/cgse_pkg.sv
// ----------------------------------------------------------------------------
// cgse_pkg
// Types and fixed constants shared by the compact genetic search engine.
// ----------------------------------------------------------------------------
package cgse_pkg;

    // Field widths fixed by the item format.
    localparam int PROB_W     = 17;
    localparam int STEP_W     = 16;
    localparam int ACT_W      = 9;
    localparam int IDX_W      = 8;
    localparam int UNI_W      = 16;
    localparam int COST_W     = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Probability constants in Q1.16, one being 65536.
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;
    localparam logic [PROB_W-1:0] PROB_HALF = 17'd32768;
    localparam logic [PROB_W-1:0] PROB_ZERO = 17'd0;
    localparam logic [PROB_W-1:0] CONV_LOW  = 17'd66;
    localparam logic [PROB_W-1:0] CONV_HIGH = 17'd65470;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_BITS = 2'd1;
    localparam logic [STEP_W-1:0]     STEP_RST        = 16'd655;
    localparam logic [ACT_W-1:0]      ACTIVE_RST      = 9'd256;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_JUDGE  = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         bit_index;
        logic [UNI_W-1:0]         uniform_first;
        logic [UNI_W-1:0]         uniform_second;
        logic signed [COST_W-1:0] cost_first;
        logic signed [COST_W-1:0] cost_second;
    } t_in_item;

    typedef struct packed {
        logic bit_first;
        logic bit_second;
        logic converged;
    } t_out_item;

    // Control into the probability update unit.
    typedef struct packed {
        logic move;
        logic win_bit;
    } t_upd_ctrl;

    // Result from the probability update unit.
    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              settled;
    } t_upd_res;

endpackage

FILE: rtl/cgse_in_if.sv
// ----------------------------------------------------------------------------
// cgse_in_if
// Valid/ready channel carrying input items into the engine.
// ----------------------------------------------------------------------------
interface cgse_in_if import cgse_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cgse_out_if.sv
// ----------------------------------------------------------------------------
// cgse_out_if
// Valid/ready channel carrying result items out of the engine.
// ----------------------------------------------------------------------------
interface cgse_out_if import cgse_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cgse_prob_unit.sv
// ----------------------------------------------------------------------------
// cgse_prob_unit
// Shared update unit: moves one probability by the step towards the winning
// bit with saturation, and tests the new value for convergence.
// ----------------------------------------------------------------------------
module cgse_prob_unit import cgse_pkg::*; (
    input  logic [PROB_W-1:0] i_prob,
    input  logic [STEP_W-1:0] i_step,
    input  t_upd_ctrl         i_ctrl,
    output t_upd_res          o_res
);

    logic [PROB_W:0]   w_room;
    logic [PROB_W-1:0] w_up;
    logic [PROB_W-1:0] w_down;
    logic [PROB_W-1:0] w_new;

    // Saturating move up or down by the step.
    always_comb begin
        w_room = {1'b0, PROB_ONE} - {1'b0, i_prob};
        if (w_room < (PROB_W+1)'(i_step)) begin
            w_up = PROB_ONE;
        end else begin
            w_up = i_prob + PROB_W'(i_step);
        end
        if (i_prob < PROB_W'(i_step)) begin
            w_down = PROB_ZERO;
        end else begin
            w_down = i_prob - PROB_W'(i_step);
        end
        if (i_ctrl.move) begin
            w_new = i_ctrl.win_bit ? w_up : w_down;
        end else begin
            w_new = i_prob;
        end
    end

    // Convergence test on the updated value.
    assign o_res.prob    = w_new;
    assign o_res.settled = (w_new <= CONV_LOW) || (w_new >= CONV_HIGH);

endmodule

FILE: rtl/compact_genetic_search_engine_top.sv
// ----------------------------------------------------------------------------
// compact_genetic_search_engine_top
// Compact genetic algorithm engine: probability vector, two sampled
// chromosomes, sampling and judging over one shared update unit.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in. A sample item (kind 0) draws one bit position of
// both chromosomes; a judge item (kind 1) compares the two costs and updates
// every active probability where the chromosomes differ. Exactly one result
// item leaves on o_out per input item, in order.
// A sample item reads its probability entry and then draws and stores both bits.
// A judge item visits N entries, N being min(active_bits, MAX_BITS): the
// sequencer walks the probability memory one entry per cycle through its
// single read and write port and the shared update unit.
// After reset the block sweeps the probability memory to one half,
// with i_in.ready low; configuration writes are taken at any
// time through i_cfg_we, i_cfg_addr and i_cfg_wdata.
// The result sits in an output register, so a new item is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// block holds that result and accepts nothing more until the register frees.
// ----------------------------------------------------------------------------
module compact_genetic_search_engine_top import cgse_pkg::*; #(
    parameter int MAX_BITS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cgse_in_if.sink               i_in,
    cgse_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW     = $clog2(MAX_BITS);
    localparam int WORD_W = PROB_W + 2;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SAMPLE = 3'd2;
    localparam logic [2:0] ST_JUDGE  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // Memory word: probability, chromosome one bit, chromosome two bit.
    logic [WORD_W-1:0] r_mem [MAX_BITS];
    logic [WORD_W-1:0] r_rd_word;

    logic [2:0]        r_state;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_last;
    logic [UNI_W-1:0]  r_u1;
    logic [UNI_W-1:0]  r_u2;
    logic              r_second_wins;
    logic              r_settled;
    logic [STEP_W-1:0] r_step;
    logic [ACT_W-1:0]  r_active;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_out_valid;

    logic              w_acc;
    logic              w_in_range;
    logic [AW-1:0]     w_last;
    logic [AW-1:0]     w_rd_addr;
    logic              w_mem_we;
    logic [WORD_W-1:0] w_wr_data;
    logic [PROB_W-1:0] w_rd_prob;
    logic              w_rd_c1;
    logic              w_rd_c2;
    logic              w_b1;
    logic              w_b2;
    logic              w_settled_all;
    logic              w_fin;
    t_out_item         w_fin_res;
    logic              w_out_free;
    t_upd_ctrl         w_upd_ctrl;
    t_upd_res          w_upd_res;

    assign i_in.ready    = (r_state == ST_IDLE);
    assign w_acc         = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
    assign w_out_free    = !r_out_valid || o_out.ready;

    assign w_rd_prob = r_rd_word[WORD_W-1:2];
    assign w_rd_c1   = r_rd_word[1];
    assign w_rd_c2   = r_rd_word[0];

    // Position check and index of the last active entry.
    assign w_in_range = (32'(i_in.payload.bit_index) < MAX_BITS);
    assign w_last = (32'(r_active) >= MAX_BITS) ? AW'(MAX_BITS - 1)
                                                : AW'(r_active - 9'd1);

    // Sample comparison on the registered probability.
    assign w_b1 = ({1'b0, r_u1} < w_rd_prob);
    assign w_b2 = ({1'b0, r_u2} < w_rd_prob);

    // Shared update unit drives every judge step.
    assign w_upd_ctrl.move    = (w_rd_c1 != w_rd_c2);
    assign w_upd_ctrl.win_bit = r_second_wins ? w_rd_c2 : w_rd_c1;

    cgse_prob_unit u_prob_unit (
        .i_prob (w_rd_prob),
        .i_step (r_step),
        .i_ctrl (w_upd_ctrl),
        .o_res  (w_upd_res)
    );

    assign w_settled_all = r_settled && w_upd_res.settled;

    // Memory port addressing and write data per state.
    always_comb begin
        w_mem_we  = 1'b0;
        w_wr_data = {PROB_HALF, 2'b00};
        w_rd_addr = r_idx + AW'(1);
        w_fin     = 1'b0;
        w_fin_res = r_res;
        case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (i_in.payload.kind == KIND_JUDGE) begin
                    w_rd_addr = '0;
                end else begin
                    w_rd_addr = AW'(i_in.payload.bit_index);
                end
            end
            ST_SAMPLE: begin
                w_mem_we            = 1'b1;
                w_wr_data           = {w_rd_prob, w_b1, w_b2};
                w_fin               = 1'b1;
                w_fin_res.bit_first  = w_b1;
                w_fin_res.bit_second = w_b2;
                w_fin_res.converged  = 1'b0;
            end
            ST_JUDGE: begin
                w_mem_we  = 1'b1;
                w_wr_data = {w_upd_res.prob, w_rd_c1, w_rd_c2};
                if (r_idx == r_last) begin
                    w_fin                = 1'b1;
                    w_fin_res.bit_first  = 1'b0;
                    w_fin_res.bit_second = 1'b0;
                    w_fin_res.converged  = w_settled_all;
                end
            end
            ST_DONE: begin
                w_fin = 1'b1;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // Probability and chromosome memory, registered read.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_wr_data;
        end
        r_rd_word <= r_mem[w_rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RST;
            r_active <= ACTIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP_SIZE:   r_step   <= i_cfg_wdata;
                CFG_ACTIVE_BITS: r_active <= i_cfg_wdata[ACT_W-1:0];
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_idx == AW'(MAX_BITS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_idx <= r_idx + AW'(1);
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_in.payload.kind == KIND_JUDGE) begin
                            r_idx   <= '0;
                            r_state <= (r_active == '0) ? ST_DONE : ST_JUDGE;
                        end else begin
                            r_idx   <= AW'(i_in.payload.bit_index);
                            r_state <= w_in_range ? ST_SAMPLE : ST_DONE;
                        end
                    end
                end
                ST_JUDGE: begin
                    if (w_fin) begin
                        r_state <= w_out_free ? ST_IDLE : ST_DONE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_SAMPLE, ST_DONE: begin
                    r_state <= w_out_free ? ST_IDLE : ST_DONE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_u1          <= i_in.payload.uniform_first;
            r_u2          <= i_in.payload.uniform_second;
            r_second_wins <= ($signed(i_in.payload.cost_second)
                              < $signed(i_in.payload.cost_first));
            r_settled     <= 1'b1;
            r_last        <= w_last;
        end else if (r_state == ST_JUDGE) begin
            r_settled <= w_settled_all;
        end
        if (w_fin) begin
            r_res <= w_fin_res;
        end else if (w_acc) begin
            // Out-of-range samples and judges with no active bits finish here.
            r_res.bit_first  <= 1'b0;
            r_res.bit_second <= 1'b0;
            r_res.converged  <= (i_in.payload.kind == KIND_JUDGE);
        end
        if (w_fin && w_out_free) begin
            r_out <= w_fin_res;
        end
    end

endmodule
